// File: design/assert_macros.svh
// =============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the timer table design.
// =============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/ocbt_pkg.sv
// =============================================================================
// ocbt_pkg
// Types and constants shared by the one-shot callback timer table modules.
// =============================================================================
package ocbt_pkg;

    // Most dispatches a single run command may produce.
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_RUN    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] task_address;
        logic [15:0] task_param;
        logic [15:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic        dispatch_valid;
        logic [31:0] dispatch_address;
        logic [15:0] dispatch_param;
        logic [31:0] system_time;
        logic        last;
    } t_out_item;

    // One table entry as held in the slot RAM.
    typedef struct packed {
        logic [31:0] address;
        logic [15:0] param;
        logic [15:0] remaining;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_ADD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input transaction
        logic add_write;  // store the new task in the current slot
        logic scan_eval;  // apply cancel or tick to the current slot
        logic select;     // take the current slot as a dispatch and free it
        logic emit_pend;  // push the held dispatch, not last
        logic finish;     // push the closing result
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic addr_zero;
        logic slot_used;
        logic slot_ready;
        logic pend_valid;
        logic out_free;
    } t_dp_sts;

endpackage

// File: design/ocbt_ram.sv
// =============================================================================
// ocbt_ram
// Generic single-write, single-read RAM with registered read data.
// =============================================================================
module ocbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ocbt_dp.sv
// =============================================================================
// ocbt_dp
// Datapath: input capture, slot table, tick counter, held dispatch and the
// output register.
// =============================================================================
module ocbt_dp
    import ocbt_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_in_item       i_in_data,
    input  t_dp_ctl        i_ctl,
    input  logic [IW-1:0]  i_rd_idx,
    input  logic [IW-1:0]  i_slot_idx,
    output t_dp_sts        o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_out_item      o_out_data
);

    t_in_item               r_in;
    logic [31:0]            r_tick;
    logic [MAX_TASKS-1:0]   r_used;
    logic [MAX_TASKS-1:0]   n_used;
    logic                   r_ok;
    logic                   r_pend_valid;
    logic [31:0]            r_pend_addr;
    logic [15:0]            r_pend_param;
    logic                   r_out_valid;
    t_out_item              r_out;

    t_slot                  w_rd;
    t_slot                  w_wr;
    logic                   w_we;
    logic                   w_addr_zero;
    logic                   w_cur_used;
    logic                   w_cancel_hit;
    logic                   w_tick_dec;
    logic                   w_final_ok;

    ocbt_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_slot_idx),
        .i_wdata (w_wr),
        .i_raddr (i_rd_idx),
        .o_rdata (w_rd)
    );

    assign w_addr_zero  = (r_in.task_address == 32'd0);
    assign w_cur_used   = r_used[i_slot_idx];
    assign w_cancel_hit = i_ctl.scan_eval && (r_in.cmd == CMD_CANCEL) && w_cur_used &&
                          !w_addr_zero && (w_rd.address == r_in.task_address);
    assign w_tick_dec   = i_ctl.scan_eval && (r_in.cmd == CMD_TICK) && w_cur_used &&
                          (w_rd.remaining != 16'd0);
    assign w_we         = i_ctl.add_write || w_tick_dec;
    assign w_final_ok   = (r_in.cmd == CMD_TICK) || (r_in.cmd == CMD_RUN) || r_ok;

    always_comb begin
        if (i_ctl.add_write) begin
            w_wr.address   = r_in.task_address;
            w_wr.param     = r_in.task_param;
            w_wr.remaining = r_in.delay_ticks;
        end else begin
            w_wr.address   = w_rd.address;
            w_wr.param     = w_rd.param;
            w_wr.remaining = w_rd.remaining - 16'd1;
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_ctl.add_write) begin
            n_used[i_slot_idx] = 1'b1;
        end
        if (w_cancel_hit || i_ctl.select) begin
            n_used[i_slot_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_tick       <= 32'd0;
            r_ok         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used <= n_used;
            if (i_ctl.load && (i_in_data.cmd == CMD_TICK)) begin
                r_tick <= r_tick + 32'd1;
            end
            if (i_ctl.load) begin
                r_ok <= 1'b0;
            end else if (i_ctl.add_write || w_cancel_hit) begin
                r_ok <= 1'b1;
            end
            if (i_ctl.load || i_ctl.finish) begin
                r_pend_valid <= 1'b0;
            end else if (i_ctl.select) begin
                r_pend_valid <= 1'b1;
            end
            if (i_ctl.emit_pend || i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in <= i_in_data;
        end
        if (i_ctl.select) begin
            r_pend_addr  <= w_rd.address;
            r_pend_param <= w_rd.param;
        end
        if (i_ctl.emit_pend) begin
            r_out.ok               <= 1'b1;
            r_out.dispatch_valid   <= 1'b1;
            r_out.dispatch_address <= r_pend_addr;
            r_out.dispatch_param   <= r_pend_param;
            r_out.system_time      <= r_tick;
            r_out.last             <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out.ok               <= w_final_ok;
            r_out.dispatch_valid   <= r_pend_valid;
            r_out.dispatch_address <= r_pend_valid ? r_pend_addr : 32'd0;
            r_out.dispatch_param   <= r_pend_valid ? r_pend_param : 16'd0;
            r_out.system_time      <= r_tick;
            r_out.last             <= 1'b1;
        end
    end

    assign o_sts.cmd        = r_in.cmd;
    assign o_sts.addr_zero  = w_addr_zero;
    assign o_sts.slot_used  = w_cur_used;
    assign o_sts.slot_ready = w_cur_used && (w_rd.remaining == 16'd0);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/ocbt_ctrl.sv
// =============================================================================
// ocbt_ctrl
// Controller: sequences the slot scan for each command and paces the
// dispatch results against the output register.
// =============================================================================
module ocbt_ctrl
    import ocbt_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  t_dp_sts        i_sts,
    output t_dp_ctl        o_ctl,
    output logic [IW-1:0]  o_rd_idx,
    output logic [IW-1:0]  o_slot_idx
);

    t_state                r_state;
    t_state                n_state;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         n_idx;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  w_hit;
    logic                  w_stall;
    logic                  w_last_slot;

    // A ready slot is taken only while the run still has room for results.
    assign w_hit       = i_sts.slot_ready && (r_count < CNT_W'(RESULT_LIMIT));
    assign w_stall     = (i_sts.cmd == CMD_RUN) && w_hit && i_sts.pend_valid &&
                         !i_sts.out_free;
    assign w_last_slot = (r_idx == IW'(MAX_TASKS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = (i_sts.cmd == CMD_ADD) ? ST_ADD : ST_SCAN;
            end
            ST_ADD: begin
                if (i_sts.addr_zero || !i_sts.slot_used || w_last_slot) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (!w_stall && w_last_slot) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        o_rd_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            ST_PRIME: begin
                o_rd_idx = '0;
            end
            ST_ADD: begin
                o_ctl.add_write = !i_sts.addr_zero && !i_sts.slot_used;
            end
            ST_SCAN: begin
                // The next slot is fetched while this one is evaluated.
                o_ctl.scan_eval = !w_stall;
                o_ctl.select    = (i_sts.cmd == CMD_RUN) && w_hit && !w_stall;
                o_ctl.emit_pend = (i_sts.cmd == CMD_RUN) && w_hit && !w_stall &&
                                  i_sts.pend_valid;
                o_rd_idx        = w_stall ? r_idx : r_idx + IW'(1);
            end
            ST_FINISH: begin
                o_ctl.finish = i_sts.out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_count = r_count;
        case (r_state)
            ST_PRIME: begin
                n_idx   = '0;
                n_count = '0;
            end
            ST_ADD: begin
                n_idx = r_idx + IW'(1);
            end
            ST_SCAN: begin
                if (!w_stall) begin
                    n_idx = r_idx + IW'(1);
                end
                if (o_ctl.select) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    assign o_slot_idx = r_idx;

endmodule

// File: design/oneshot_callback_timer_table_core.sv
// =============================================================================
// oneshot_callback_timer_table_core
// Table of one-shot timed callbacks with add, cancel, tick and run commands.
// =============================================================================
// The input channel carries one command per transaction; the output channel
// returns the results that command causes, the closing one marked by last.
// Add, cancel and tick give exactly one result. Run gives one result per
// dispatched task in slot order (at most 16), or a single result with no
// dispatch when no task is ready.
// Cancel, tick and run pass from acceptance to their final result through a
// prime step for the slot RAM read, a scan of every slot, a load of the
// output register and the receiver's handshake. An add stops its scan at
// the first free slot, or at once on a zero address. The next command is
// accepted in the cycle after the final result enters the output register.
// A stalled receiver holds the output register; a run then pauses its scan
// until the waiting result is taken. Results never get lost or reordered.
// Reset clears the slot valid bits and the system time; the slot RAM itself
// is not cleared, since a slot is read only while its valid bit is set.
// =============================================================================
`include "assert_macros.svh"

module oneshot_callback_timer_table_core
    import ocbt_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    t_dp_ctl        w_ctl;
    t_dp_sts        w_sts;
    logic [IW-1:0]  w_rd_idx;
    logic [IW-1:0]  w_slot_idx;

    ocbt_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_rd_idx   (w_rd_idx),
        .o_slot_idx (w_slot_idx)
    );

    ocbt_dp #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (w_ctl),
        .i_rd_idx    (w_rd_idx),
        .i_slot_idx  (w_slot_idx),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `ASSERT_ALWAYS(a_idle_no_pending, !(o_in_ready && w_sts.pend_valid), "held dispatch while idle")
    `ASSERT_IMPLIES(a_push_has_room, w_ctl.emit_pend || w_ctl.finish, w_sts.out_free, "push into full output register")
    `ASSERT_IMPLIES(a_add_into_free, w_ctl.add_write, !w_sts.slot_used, "add overwrote a used slot")
    `ASSERT_IMPLIES(a_nodispatch_last, o_out_valid && !o_out_data.dispatch_valid, o_out_data.last, "result without dispatch not last")

endmodule

// File: test/tb.sv
// =============================================================================
// tb
// Self-checking testbench for the one-shot callback timer table.
// =============================================================================
// Directed commands cover the field extremes, the empty and full table and
// the cancel corner cases. Random traffic follows them: mostly well-formed
// add, cancel, tick and run mixes over a small set of callback keys, with
// fully random noise and occasional fill-and-drain rounds. A model of the
// table inside the bench predicts every result, and the checker compares
// each output transaction with the oldest prediction.
// =============================================================================
`timescale 1ns / 1ps

module tb;
    import ocbt_pkg::*;

    localparam int MAX_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int KEY_COUNT    = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    oneshot_callback_timer_table_core #(
        .MAX_TASKS (MAX_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shadow copy of the table and the results it still owes.
    bit          slot_busy [MAX_SLOTS];
    t_slot       slot_entry[MAX_SLOTS];
    logic [31:0] tick_total = '0;
    t_out_item   due_results[$];

    logic [31:0] task_keys[KEY_COUNT];
    int          fail_count   = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    logic        hold_off_req = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one command to the shadow table and queues the results it causes.
    function automatic void timer_table_step(input t_in_item item);
        t_out_item res;
        int        ready_slots[$];
        bit        placed;
        res    = '0;
        placed = 1'b0;
        case (item.cmd)
            CMD_ADD: begin
                if (item.task_address != '0) begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (!placed && !slot_busy[i]) begin
                            slot_busy[i]            = 1'b1;
                            slot_entry[i].address   = item.task_address;
                            slot_entry[i].param     = item.task_param;
                            slot_entry[i].remaining = item.delay_ticks;
                            placed                  = 1'b1;
                        end
                    end
                end
                res.ok = placed;
            end
            CMD_CANCEL: begin
                if (item.task_address != '0) begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (slot_busy[i] && slot_entry[i].address == item.task_address) begin
                            slot_busy[i] = 1'b0;
                            res.ok       = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                tick_total = tick_total + 32'd1;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (slot_busy[i] && slot_entry[i].remaining != '0)
                        slot_entry[i].remaining = slot_entry[i].remaining - 16'd1;
                end
                res.ok = 1'b1;
            end
            default: begin
                res.ok = 1'b1;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (slot_busy[i] && slot_entry[i].remaining == '0 &&
                        ready_slots.size() < RESULT_LIMIT)
                        ready_slots.push_back(i);
                end
                foreach (ready_slots[k]) begin
                    res.dispatch_valid   = 1'b1;
                    res.dispatch_address = slot_entry[ready_slots[k]].address;
                    res.dispatch_param   = slot_entry[ready_slots[k]].param;
                    res.system_time      = tick_total;
                    res.last             = (k == ready_slots.size() - 1);
                    slot_busy[ready_slots[k]] = 1'b0;
                    due_results.push_back(res);
                end
            end
        endcase
        if (ready_slots.size() == 0) begin
            res.system_time = tick_total;
            res.last        = 1'b1;
            due_results.push_back(res);
        end
    endfunction

    function automatic t_in_item cmd_item(input t_cmd op, input logic [31:0] addr,
                                          input logic [15:0] arg, input logic [15:0] ticks);
        t_in_item item;
        item.cmd          = op;
        item.task_address = addr;
        item.task_param   = arg;
        item.delay_ticks  = ticks;
        return item;
    endfunction

    // Offers one command until accepted, then possibly leaves a gap after it.
    task automatic send_cmd(input t_in_item item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        timer_table_step(item);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
    endtask

    task automatic test_edge_fields();
        send_cmd(cmd_item(CMD_RUN, 32'h0, 16'h0, 16'h0));
        send_cmd(cmd_item(CMD_ADD, 32'h0, 16'hFFFF, 16'h0));
        send_cmd(cmd_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(cmd_item(CMD_CANCEL, 32'h0, 16'h0, 16'h0));
        send_cmd(cmd_item(CMD_CANCEL, 32'h5, 16'h0, 16'h0));
        send_cmd(cmd_item(CMD_CANCEL, 32'hFFFF_FFFF, 16'h0, 16'h0));
        wait_results_drained();
    endtask

    // Fills every slot, with two slots sharing one key, and then empties the table.
    task automatic test_full_table();
        logic [31:0] addr;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            addr = (i == 3 || i == 9) ? 32'hA5A5_5A5A : 32'h100 + i;
            if (i == 0)
                send_cmd(cmd_item(CMD_ADD, 32'h1, 16'h0, 16'h0));
            else
                send_cmd(cmd_item(CMD_ADD, addr, 16'($urandom_range(0, 65535)), 16'(i % 2)));
        end
        send_cmd(cmd_item(CMD_ADD, 32'h7777, 16'h1234, 16'h0));
        send_cmd(cmd_item(CMD_CANCEL, 32'hA5A5_5A5A, 16'h0, 16'h0));
        send_cmd(cmd_item(CMD_TICK, 32'h0, 16'h0, 16'h0));
        send_cmd(cmd_item(CMD_RUN, 32'h0, 16'h0, 16'h0));
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int          start_count;
        int          next_drain;
        int          pick;
        int          sel;
        bit          hold_done;
        logic [31:0] addr;
        logic [15:0] ticks;
        t_cmd        op;
        start_count = items_sent;
        next_drain  = items_sent + 90;
        hold_done   = 1'b0;
        foreach (task_keys[k]) begin
            do task_keys[k] = $urandom(); while (task_keys[k] == '0);
        end
        while (items_sent - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
                // Clear the table, then fill it with ready tasks so one run
                // dispatches every slot.
                foreach (task_keys[k])
                    send_cmd(cmd_item(CMD_CANCEL, task_keys[k], 16'h0, 16'h0));
                repeat (8) send_cmd(cmd_item(CMD_TICK, $urandom(), 16'h0, 16'h0));
                send_cmd(cmd_item(CMD_RUN, $urandom(), 16'h0, 16'h0));
                for (int i = 0; i < MAX_SLOTS; i++)
                    send_cmd(cmd_item(CMD_ADD, task_keys[$urandom_range(0, KEY_COUNT - 1)],
                                      16'($urandom_range(0, 65535)), 16'h0));
                send_cmd(cmd_item(CMD_RUN, 32'h0, 16'h0, 16'h0));
            end else if (pick < 8) begin
                // Noise; random keys get short delays so they never clog the table.
                op    = t_cmd'($urandom_range(0, 3));
                ticks = (op == CMD_ADD) ? 16'($urandom_range(0, 7))
                                        : 16'($urandom_range(0, 65535));
                send_cmd(cmd_item(op, $urandom(), 16'($urandom_range(0, 65535)), ticks));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 94)
                    addr = task_keys[$urandom_range(0, KEY_COUNT - 1)];
                else if (sel < 97)
                    addr = 32'h0;
                else
                    addr = $urandom();
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    ticks = 16'($urandom_range(0, 3));
                else if (sel < 19)
                    ticks = 16'($urandom_range(4, 40));
                else
                    ticks = 16'($urandom_range(0, 65535));
                if (pick < 48)
                    op = CMD_ADD;
                else if (pick < 62)
                    op = CMD_CANCEL;
                else if (pick < 83)
                    op = CMD_TICK;
                else
                    op = CMD_RUN;
                send_cmd(cmd_item(op, addr, 16'($urandom_range(0, 65535)), ticks));
            end
            if (!hold_done && items_sent - start_count >= RANDOM_ITEMS / 3) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (items_sent >= next_drain) begin
                wait_results_drained();
                next_drain = items_sent + $urandom_range(60, 120);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_fields();
        test_full_table();
        test_random_traffic();
        wait_results_drained();
        repeat (2 * MAX_SLOTS + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver switches between stall patterns, and on request refuses
    // results for a long stretch so the block backs up into its input.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result transaction: %p", o_out_data);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("ok", want.ok, o_out_data.ok);
                check_field("dispatch_valid", want.dispatch_valid, o_out_data.dispatch_valid);
                check_field("dispatch_address", want.dispatch_address,
                            o_out_data.dispatch_address);
                check_field("dispatch_param", want.dispatch_param, o_out_data.dispatch_param);
                check_field("system_time", want.system_time, o_out_data.system_time);
                check_field("last", want.last, o_out_data.last);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+design
design/ocbt_pkg.sv
design/ocbt_ram.sv
design/ocbt_dp.sv
design/ocbt_ctrl.sv
design/oneshot_callback_timer_table_core.sv
test/tb.sv
